FILE: rtl/range_adaptive_point_grouper_macros.svh
// assertion macros for the range adaptive point grouper
// no dependencies; taken in by the top level with an include
`ifndef RANGE_ADAPTIVE_POINT_GROUPER_MACROS_SVH
`define RANGE_ADAPTIVE_POINT_GROUPER_MACROS_SVH
`ifndef SYNTHESIS
`define RAPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rapg check failed in the same cycle");
`define RAPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rapg check failed one cycle later");
`else
`define RAPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define RAPG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/rapg_pkg.sv
// shared constants, codes and types of the range adaptive point grouper
// no dependencies; used by every other file but rapg_isqrt and the macros
package rapg_pkg;

   localparam int DEF_MAX_SCAN_POINTS = 4096;
   localparam int DEF_COORD_BITS      = 16;

   localparam int GAP_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int MIN_W       = 13;
   localparam int IDX_OUT_W   = 12;
   localparam int CNT_OUT_W   = 13;
   localparam int SQ_SAT_BITS = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_GAP      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_PER_RANGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS    = 2'd2;

   localparam logic [GAP_W-1:0] RST_BASE_GAP      = 16'd100;
   localparam logic [GAP_W-1:0] RST_GAP_PER_RANGE = 16'd402;
   localparam logic [MIN_W-1:0] RST_MIN_POINTS    = 13'd5;

   typedef enum logic [2:0] {
      MUL_AX,
      MUL_AY,
      MUL_DX,
      MUL_DY,
      MUL_RG,
      MUL_T
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       diff_ld;
      logic       mul_en;
      mul_op_type mul_op;
      logic       acc_ld;
      logic       rad_ld;
      logic       d2_ld;
      logic       sqrt_start;
      logic       thr_ld;
      logic       commit;
      logic       emit1;
      logic       emit2;
   } dp_cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic pend1;
      logic pend2;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] first;
      logic [IDX_OUT_W-1:0] last;
      logic [CNT_OUT_W-1:0] count;
   } group_type;

endpackage

FILE: rtl/rapg_if.sv
// point and group channel interfaces of the range adaptive point grouper
// depends on rapg_pkg for field widths
interface rapg_req_if #(
   parameter int COORD_BITS = rapg_pkg::DEF_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         scan_end;

   modport source (output valid, output point_x, output point_y, output scan_end,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input scan_end,
                 output ready);
endinterface

interface rapg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rapg_pkg::IDX_OUT_W-1:0]     group_first;
   logic [rapg_pkg::IDX_OUT_W-1:0]     group_last;
   logic [rapg_pkg::CNT_OUT_W-1:0]     group_count;
   logic                               run_last;

   modport source (output valid, output group_first, output group_last,
                   output group_count, output run_last, input ready);
   modport sink (input valid, input group_first, input group_last,
                 input group_count, input run_last, output ready);
endinterface

FILE: rtl/rapg_isqrt.sv
// digit by digit integer square root, one result bit per cycle
// no package dependencies; used by rapg_datapath
module rapg_isqrt #(
   parameter int RW = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [2*RW-1:0] value,
   output logic [RW-1:0]   root,
   output logic            done
);

   localparam int VW   = 2 * RW;
   localparam int REMW = RW + 2;
   localparam int CNTW = $clog2(RW);

   logic            busy_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [VW-1:0]   val_ff;
   logic [REMW-1:0] rem_ff;
   logic [RW-1:0]   root_ff;

   logic [REMW+1:0] rem_sh;
   logic [REMW+1:0] trial;
   logic [REMW-1:0] rem_in;
   logic [RW-1:0]   root_in;

   always_comb begin
      rem_sh  = {rem_ff, val_ff[VW-1 -: 2]};
      trial   = (REMW+2)'({root_ff, 2'b01});
      if (rem_sh >= trial) begin
         rem_in  = REMW'(rem_sh - trial);
         root_in = {root_ff[RW-2:0], 1'b1};
      end else begin
         rem_in  = REMW'(rem_sh);
         root_in = {root_ff[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(RW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= val_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
   assign done = !busy_ff;

endmodule

FILE: rtl/rapg_datapath.sv
// datapath: input and config registers, shared multiplier, root unit,
// group bookkeeping and the output register; depends on rapg_pkg, rapg_isqrt
module rapg_datapath #(
   parameter int MAX_SCAN_POINTS = rapg_pkg::DEF_MAX_SCAN_POINTS,
   parameter int COORD_BITS      = rapg_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rapg_pkg::dp_cmd_type              cmd,
   output rapg_pkg::dp_status_type           stat,
   input  logic signed [COORD_BITS-1:0]      req_point_x,
   input  logic signed [COORD_BITS-1:0]      req_point_y,
   input  logic                              req_scan_end,
   input  logic                              csr_we,
   input  logic [rapg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rapg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rapg_pkg::IDX_OUT_W-1:0]    rsp_group_first,
   output logic [rapg_pkg::IDX_OUT_W-1:0]    rsp_group_last,
   output logic [rapg_pkg::CNT_OUT_W-1:0]    rsp_group_count,
   output logic                              rsp_run_last
);

   localparam int C    = COORD_BITS;
   localparam int IW   = $clog2(MAX_SCAN_POINTS);
   localparam int NW   = $clog2(MAX_SCAN_POINTS + 1);
   localparam int TW   = ((C > rapg_pkg::GAP_W) ? C : rapg_pkg::GAP_W) + 1;
   localparam int MW   = TW;
   localparam int PW   = 2 * MW;
   localparam int ACCW = 2 * C;
   localparam int RADW = 2 * C;
   localparam int D2W  = 2 * C + 1;
   localparam int CMPW = (D2W > PW) ? D2W : PW;
   localparam int SZW  = (NW > rapg_pkg::MIN_W) ? NW : rapg_pkg::MIN_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SCAN_POINTS - 1);
   localparam logic [NW-1:0] MAX_SIZE = NW'(MAX_SCAN_POINTS);

   // configuration
   logic [rapg_pkg::GAP_W-1:0] base_gap_ff;
   logic [rapg_pkg::GAP_W-1:0] gap_ff;
   logic [rapg_pkg::MIN_W-1:0] min_ff;

   // current point
   logic signed [C-1:0] x_ff;
   logic signed [C-1:0] y_ff;
   logic                last_ff;
   logic [C-1:0]        ax_ff;
   logic [C-1:0]        ay_ff;
   logic [C-1:0]        dxm_ff;
   logic [C-1:0]        dym_ff;

   // arithmetic
   logic [MW-1:0]   mul_a;
   logic [MW-1:0]   mul_b;
   logic [PW-1:0]   prod_ff;
   logic [ACCW-1:0] acc_ff;
   logic [RADW-1:0] rad_ff;
   logic [D2W-1:0]  d2_ff;
   logic [TW-1:0]   t_ff;
   logic [C-1:0]    root;
   logic            sqrt_done;

   // group state
   logic signed [C-1:0] prev_x_ff;
   logic signed [C-1:0] prev_y_ff;
   logic [IW-1:0]       gstart_ff;
   logic [NW-1:0]       gsize_ff;
   logic [IW-1:0]       pidx_ff;

   logic                pend1_ff;
   logic                pend2_ff;
   rapg_pkg::group_type res1_ff;
   rapg_pkg::group_type res2_ff;
   rapg_pkg::group_type out_ff;
   logic                out_last_ff;
   logic                out_valid_ff;

   // combinational values
   logic [C-1:0]        ax_in;
   logic [C-1:0]        ay_in;
   logic signed [C:0]   dx_s;
   logic signed [C:0]   dy_s;
   logic [C-1:0]        dxm_in;
   logic [C-1:0]        dym_in;
   logic                t_ok;
   logic                brk;
   logic [IW-1:0]       before_idx;
   logic [NW-1:0]       size_kept;
   logic [IW-1:0]       gstart_in;
   logic [NW-1:0]       gsize_in;
   logic [IW-1:0]       pidx_in;
   logic                pend1_in;
   logic                pend2_in;
   rapg_pkg::group_type res1_in;
   rapg_pkg::group_type res2_in;
   logic                out_free;

   rapg_isqrt #(
      .RW (C)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (rad_ff),
      .root  (root),
      .done  (sqrt_done)
   );

   // magnitudes; the most negative code maps to its unsigned magnitude
   always_comb begin
      ax_in  = req_point_x[C-1] ? $unsigned(-req_point_x) : $unsigned(req_point_x);
      ay_in  = req_point_y[C-1] ? $unsigned(-req_point_y) : $unsigned(req_point_y);
      dx_s   = {x_ff[C-1], x_ff} - {prev_x_ff[C-1], prev_x_ff};
      dy_s   = {y_ff[C-1], y_ff} - {prev_y_ff[C-1], prev_y_ff};
      dxm_in = dx_s[C] ? C'($unsigned(-dx_s)) : C'($unsigned(dx_s));
      dym_in = dy_s[C] ? C'($unsigned(-dy_s)) : C'($unsigned(dy_s));
   end

   always_comb begin
      case (cmd.mul_op)
         rapg_pkg::MUL_AX: begin
            mul_a = MW'(ax_ff);
            mul_b = MW'(ax_ff);
         end
         rapg_pkg::MUL_AY: begin
            mul_a = MW'(ay_ff);
            mul_b = MW'(ay_ff);
         end
         rapg_pkg::MUL_DX: begin
            mul_a = MW'(dxm_ff);
            mul_b = MW'(dxm_ff);
         end
         rapg_pkg::MUL_DY: begin
            mul_a = MW'(dym_ff);
            mul_b = MW'(dym_ff);
         end
         rapg_pkg::MUL_RG: begin
            mul_a = MW'(root);
            mul_b = MW'(gap_ff);
         end
         rapg_pkg::MUL_T: begin
            mul_a = t_ff;
            mul_b = t_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // breaks need t below 2^32, which the TW-bit t always is; its square fits prod_ff
   always_comb begin
      t_ok       = TW'(t_ff >> rapg_pkg::SQ_SAT_BITS) == '0;
      brk        = (gsize_ff != '0) && t_ok && (CMPW'(d2_ff) > CMPW'(prod_ff));
      before_idx = (pidx_ff == '0) ? LAST_IDX : pidx_ff - 1'b1;
      pend1_in   = brk && (SZW'(gsize_ff) >= SZW'(min_ff));
      res1_in.first = rapg_pkg::IDX_OUT_W'(gstart_ff);
      res1_in.last  = rapg_pkg::IDX_OUT_W'(before_idx);
      res1_in.count = rapg_pkg::CNT_OUT_W'(gsize_ff);
      size_kept  = brk ? '0 : gsize_ff;
      if (size_kept == '0) begin
         gstart_in = pidx_ff;
         gsize_in  = NW'(1);
      end else begin
         gstart_in = gstart_ff;
         gsize_in  = (size_kept < MAX_SIZE) ? size_kept + 1'b1 : size_kept;
      end
      pend2_in   = last_ff && (SZW'(gsize_in) >= SZW'(min_ff));
      res2_in.first = rapg_pkg::IDX_OUT_W'(gstart_in);
      res2_in.last  = rapg_pkg::IDX_OUT_W'(pidx_ff);
      res2_in.count = rapg_pkg::CNT_OUT_W'(gsize_in);
      if (last_ff || pidx_ff == LAST_IDX) begin
         pidx_in = '0;
      end else begin
         pidx_in = pidx_ff + 1'b1;
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_gap_ff  <= rapg_pkg::RST_BASE_GAP;
         gap_ff       <= rapg_pkg::RST_GAP_PER_RANGE;
         min_ff       <= rapg_pkg::RST_MIN_POINTS;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         gstart_ff    <= '0;
         gsize_ff     <= '0;
         pidx_ff      <= '0;
         pend1_ff     <= 1'b0;
         pend2_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rapg_pkg::CSR_BASE_GAP:      base_gap_ff <= csr_wdata;
               rapg_pkg::CSR_GAP_PER_RANGE: gap_ff      <= csr_wdata;
               rapg_pkg::CSR_MIN_POINTS:    min_ff      <= rapg_pkg::MIN_W'(csr_wdata);
               default: ;
            endcase
         end
         if (cmd.commit) begin
            prev_x_ff <= x_ff;
            prev_y_ff <= y_ff;
            gstart_ff <= gstart_in;
            gsize_ff  <= last_ff ? '0 : gsize_in;
            pidx_ff   <= pidx_in;
            pend1_ff  <= pend1_in;
            pend2_ff  <= pend2_in;
         end else if (cmd.emit1) begin
            pend1_ff <= 1'b0;
         end else if (cmd.emit2) begin
            pend2_ff <= 1'b0;
         end
         if (cmd.emit1 || cmd.emit2) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_point_x;
         y_ff    <= req_point_y;
         last_ff <= req_scan_end;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
      end
      if (cmd.diff_ld) begin
         dxm_ff <= dxm_in;
         dym_ff <= dym_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= PW'(mul_a) * PW'(mul_b);
      end
      if (cmd.acc_ld) begin
         acc_ff <= ACCW'(prod_ff);
      end
      if (cmd.rad_ld) begin
         rad_ff <= RADW'(acc_ff) + RADW'(prod_ff);
      end
      if (cmd.d2_ld) begin
         d2_ff <= D2W'(acc_ff) + D2W'(prod_ff);
      end
      if (cmd.thr_ld) begin
         t_ff <= TW'(base_gap_ff) + TW'(prod_ff >> rapg_pkg::FRAC_W);
      end
      if (cmd.commit) begin
         res1_ff <= res1_in;
         res2_ff <= res2_in;
      end
      if (cmd.emit1) begin
         out_ff      <= res1_ff;
         out_last_ff <= !pend2_ff;
      end else if (cmd.emit2) begin
         out_ff      <= res2_ff;
         out_last_ff <= 1'b1;
      end
   end

   always_comb begin
      stat.sqrt_done = sqrt_done;
      stat.pend1     = pend1_ff;
      stat.pend2     = pend2_ff;
      stat.out_free  = out_free;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_group_first = out_ff.first;
   assign rsp_group_last  = out_ff.last;
   assign rsp_group_count = out_ff.count;
   assign rsp_run_last    = out_last_ff;

endmodule

FILE: rtl/rapg_control.sv
// controller: sequences the shared multiplier, the root unit, the commit
// and up to two result words per point; depends on rapg_pkg
module rapg_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output rapg_pkg::dp_cmd_type    cmd,
   input  rapg_pkg::dp_status_type stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAG,
      S_SQY,
      S_SQDX,
      S_SQDY,
      S_SUMD,
      S_ROOT,
      S_MULRG,
      S_THR,
      S_MULT,
      S_DECIDE,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ready_ff && req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.diff_ld = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_op  = rapg_pkg::MUL_AX;
            state_in    = S_SQY;
         end
         S_SQY: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = rapg_pkg::MUL_AY;
            cmd.acc_ld = 1'b1;
            state_in   = S_SQDX;
         end
         S_SQDX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = rapg_pkg::MUL_DX;
            cmd.rad_ld = 1'b1;
            state_in   = S_SQDY;
         end
         S_SQDY: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_op     = rapg_pkg::MUL_DY;
            cmd.acc_ld     = 1'b1;
            cmd.sqrt_start = 1'b1;
            state_in       = S_SUMD;
         end
         S_SUMD: begin
            cmd.d2_ld = 1'b1;
            state_in  = S_ROOT;
         end
         S_ROOT: begin
            if (stat.sqrt_done) begin
               state_in = S_MULRG;
            end
         end
         S_MULRG: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = rapg_pkg::MUL_RG;
            state_in   = S_THR;
         end
         S_THR: begin
            cmd.thr_ld = 1'b1;
            state_in   = S_MULT;
         end
         S_MULT: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = rapg_pkg::MUL_T;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.commit = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // break word goes out before the flush word
            if (stat.pend1) begin
               cmd.emit1 = stat.out_free;
            end else if (stat.pend2) begin
               cmd.emit2 = stat.out_free;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: rtl/range_adaptive_point_grouper.sv
// Range adaptive point grouper. Points of a laser scan come in on req_if in
// scan order (x, y in millimetres, scan_end on the last point). A point opens
// a new group when its squared gap to the previous point exceeds the square
// of base_gap_mm + floor(range * gap_per_range / 2^16), range = floor(|p|).
// Each closed group of at least min_points points goes out on rsp_if as one
// word (first index, last index, count); run_last marks the last word a point
// causes. A breaking point that also ends the scan can give two words.
// Points are taken one at a time: the next is accepted only once the last has
// committed and loaded its words. The bit-serial square root of the range
// takes most of the work per point, the rest being steps of the one shared
// multiplier, the sums and the commit.
// Reset is synchronous: it clears the group state and loads the register
// defaults (100, 402, 5). A stalled rsp_if holds its word in the output
// register; the next point is still taken and worked on, and waits only when
// its own word needs that register. csr_we writes register csr_index.
// depends on rapg_pkg, rapg_if, rapg_control, rapg_datapath and the macros
`include "range_adaptive_point_grouper_macros.svh"

module range_adaptive_point_grouper #(
   parameter int MAX_SCAN_POINTS = rapg_pkg::DEF_MAX_SCAN_POINTS,
   parameter int COORD_BITS      = rapg_pkg::DEF_COORD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   rapg_req_if.sink                        req_if,
   rapg_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [rapg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rapg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rapg_pkg::dp_cmd_type    cmd;
   rapg_pkg::dp_status_type stat;
   logic                    ctl_ready;

   rapg_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctl_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rapg_datapath #(
      .MAX_SCAN_POINTS (MAX_SCAN_POINTS),
      .COORD_BITS      (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_point_x     (req_if.point_x),
      .req_point_y     (req_if.point_y),
      .req_scan_end    (req_if.scan_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_group_first (rsp_if.group_first),
      .rsp_group_last  (rsp_if.group_last),
      .rsp_group_count (rsp_if.group_count),
      .rsp_run_last    (rsp_if.run_last)
   );

   assign req_if.ready = ctl_ready;

   // one point in flight at a time
   `RAPG_ASSERT_NXT(a_accept_blocks_next, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   // a word is only loaded when the output register is free
   `RAPG_ASSERT_IMP(a_emit_into_free, clock, reset, cmd.emit1 || cmd.emit2, stat.out_free)
   // the root unit is never restarted mid run
   `RAPG_ASSERT_IMP(a_sqrt_start_idle, clock, reset, cmd.sqrt_start, stat.sqrt_done)
   // break word and flush word never load together
   `RAPG_ASSERT_IMP(a_single_emit, clock, reset, cmd.emit1, !cmd.emit2)

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for range_adaptive_point_grouper: drives scans of points,
// predicts the reported groups and compares every group word field by field
// depends on rapg_pkg, rapg_if and the grouper rtl
module tb_top;
   import rapg_pkg::*;

   localparam int COORD_W        = DEF_COORD_BITS;
   localparam int MAX_POINTS     = DEF_MAX_SCAN_POINTS;
   localparam int RANDOM_POINTS  = 725;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [IDX_OUT_W-1:0] first;
      logic [IDX_OUT_W-1:0] last;
      logic [CNT_OUT_W-1:0] count;
      logic                 run_last;
   } group_word_type;

   // mirrors the grouping state and checks group words in order
   class group_tracker_type;
      group_word_type            pending_groups[$];
      int                        mismatches;
      logic [GAP_W-1:0]          base_gap;
      logic [FRAC_W-1:0]         range_gain;
      logic [MIN_W-1:0]          min_count;
      logic signed [COORD_W-1:0] last_x;
      logic signed [COORD_W-1:0] last_y;
      logic [IDX_OUT_W-1:0]      open_first;
      logic [IDX_OUT_W-1:0]      next_index;
      int                        open_size;

      function new();
         mismatches = 0;
         base_gap   = RST_BASE_GAP;
         range_gain = RST_GAP_PER_RANGE;
         min_count  = RST_MIN_POINTS;
         last_x     = '0;
         last_y     = '0;
         open_first = '0;
         next_index = '0;
         open_size  = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BASE_GAP: base_gap = val[GAP_W-1:0];
            CSR_GAP_PER_RANGE: range_gain = val[FRAC_W-1:0];
            CSR_MIN_POINTS: min_count = val[MIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return pending_groups.size();
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function group_word_type make_word(logic [IDX_OUT_W-1:0] first,
                                         logic [IDX_OUT_W-1:0] last, int count);
         group_word_type w;
         w.first    = first;
         w.last     = last;
         w.count    = CNT_OUT_W'(count);
         w.run_last = 1'b0;
         return w;
      endfunction

      function void take_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                               logic scan_end);
         longint               ax, ay, dx, dy;
         longint unsigned      reach, thr, gap2;
         logic [IDX_OUT_W-1:0] idx, prior;
         group_word_type       caused[$];
         idx = next_index;
         if (open_size != 0) begin
            ax = longint'(px);
            ay = longint'(py);
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            reach = floor_root(ax * ax + ay * ay);
            thr   = base_gap + ((reach * range_gain) >> FRAC_W);
            dx = longint'(px) - longint'(last_x);
            dy = longint'(py) - longint'(last_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            gap2 = dx * dx + dy * dy;
            // breaking point closes the open group and starts the next one
            if (gap2 > thr * thr) begin
               prior = idx - 1'b1;
               if (open_size >= int'(min_count))
                  caused = {caused, make_word(open_first, prior, open_size)};
               open_size = 0;
            end
         end
         if (open_size == 0) begin
            open_first = idx;
            open_size  = 1;
         end else if (open_size < MAX_POINTS) begin
            open_size++;
         end
         last_x = px;
         last_y = py;
         if (scan_end) begin
            if (open_size >= int'(min_count))
               caused = {caused, make_word(open_first, idx, open_size)};
            open_size  = 0;
            next_index = '0;
         end else begin
            next_index = idx + 1'b1;
         end
         if (caused.size() > 0) caused[caused.size() - 1].run_last = 1'b1;
         pending_groups = {pending_groups, caused};
      endfunction

      function void check_group(group_word_type got);
         group_word_type want;
         if (pending_groups.size() == 0) begin
            $error("unexpected group word first %0d last %0d count %0d run_last %0d",
                   got.first, got.last, got.count, got.run_last);
            mismatches++;
            return;
         end
         want = pending_groups.pop_front();
         if (got.first !== want.first) begin
            $error("group_first expected %0d actual %0d", want.first, got.first);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("group_last expected %0d actual %0d", want.last, got.last);
            mismatches++;
         end
         if (got.count !== want.count) begin
            $error("group_count expected %0d actual %0d", want.count, got.count);
            mismatches++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last expected %0d actual %0d", want.run_last, got.run_last);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  quiet;
   int                    points_sent;
   int                    idle_cycles;
   group_tracker_type     tracker;

   rapg_req_if #(.COORD_BITS(COORD_W)) req_ch ();
   rapg_rsp_if                         rsp_ch ();

   range_adaptive_point_grouper u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   function automatic int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // called and left at a falling edge; valid stays high for a back-to-back word
   task automatic send_point(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py, input logic scan_end);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.point_x  = px;
      req_ch.point_y  = py;
      req_ch.scan_end = scan_end;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.take_point(px, py, scan_end);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_ch.valid = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      // a point that reports nothing may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(val);
      tracker.set_reg(idx, CSR_DATA_W'(val));
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input int base, input int gain, input int min_pts);
      drain_pipeline();
      write_reg(CSR_BASE_GAP, base);
      write_reg(CSR_GAP_PER_RANGE, gain);
      write_reg(CSR_MIN_POINTS, min_pts);
   endtask

   task automatic random_config();
      int base, gain, min_pts;
      case ($urandom_range(0, 5))
         0: base = 0;
         1: base = 65535;
         5: base = $urandom_range(0, 65535);
         default: base = $urandom_range(20, 300);
      endcase
      case ($urandom_range(0, 5))
         0: gain = 0;
         1: gain = 65535;
         2: gain = $urandom_range(0, 65535);
         default: gain = $urandom_range(0, 2000);
      endcase
      case ($urandom_range(0, 9))
         0: min_pts = 0;
         1: min_pts = 4096;
         2: min_pts = $urandom_range(1, 4096);
         default: min_pts = $urandom_range(1, 6);
      endcase
      set_config(base, gain, min_pts);
   endtask

   // mostly clustered walks with occasional jumps; some scans are pure noise
   task automatic random_scan();
      int                        len, cx, cy, amp;
      logic                      noisy, stop;
      logic signed [COORD_W-1:0] raw_x, raw_y;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      noisy = ($urandom_range(0, 4) == 0);
      amp   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 80);
      cx    = int'($urandom_range(0, 40000)) - 20000;
      cy    = int'($urandom_range(0, 40000)) - 20000;
      for (int i = 0; i < len; i++) begin
         stop = (i == len - 1);
         if (noisy || $urandom_range(0, 11) == 0) begin
            if (noisy || $urandom_range(0, 1) == 0) begin
               raw_x = COORD_W'($urandom());
               raw_y = COORD_W'($urandom());
               cx = int'(raw_x);
               cy = int'(raw_y);
            end else begin
               cx = cx + int'($urandom_range(0, 6000)) - 3000;
               cy = cy + int'($urandom_range(0, 6000)) - 3000;
            end
            if (noisy && $urandom_range(0, 7) == 0) stop = 1'b1;
         end else begin
            cx = cx + int'($urandom_range(0, 2 * amp)) - amp;
            cy = cy + int'($urandom_range(0, 2 * amp)) - amp;
         end
         cx = clamp_coord(cx);
         cy = clamp_coord(cy);
         send_point(COORD_W'(cx), COORD_W'(cy), stop);
      end
   endtask

   initial begin
      int target;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.point_x  = '0;
      req_ch.point_y  = '0;
      req_ch.scan_end = 1'b0;
      quiet           = 1'b0;
      points_sent     = 0;
      tracker         = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, threshold edges, double word on a breaking scan end
      set_config(100, 402, 1);
      send_point(0, 0, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(32767, -32768, 1'b0);
      send_point(-32768, 32767, 1'b0);
      send_point(894, 0, 1'b0);
      send_point(1000, 0, 1'b0);
      send_point(1107, 0, 1'b0);
      send_point(1107, 0, 1'b1);
      send_point(5, 5, 1'b0);
      send_point(5, 6, 1'b0);
      send_point(-20000, 300, 1'b1);
      // zero threshold and min_points zero
      set_config(0, 0, 0);
      send_point(1, 0, 1'b0);
      send_point(1, 0, 1'b0);
      send_point(1, 1, 1'b0);
      send_point(-1, 1, 1'b1);
      // widest threshold, nothing reaches min_points
      set_config(65535, 65535, 4096);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b1);
      // a group too small to report
      set_config(10, 0, 3);
      send_point(0, 0, 1'b0);
      send_point(5, 0, 1'b0);
      send_point(500, 0, 1'b0);
      send_point(505, 0, 1'b0);
      send_point(510, 0, 1'b1);

      random_config();
      target = points_sent + RANDOM_POINTS;
      while (points_sent < target) begin
         if ($urandom_range(0, 3) == 0) random_config();
         quiet = ($urandom_range(0, 3) == 0);
         random_scan();
      end
      quiet = 1'b0;

      drain_pipeline();
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // group word receiver with random back-pressure
   initial begin
      int             hold;
      group_word_type got;
      hold         = 0;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold > 0) begin
            rsp_ch.ready = 1'b0;
            hold--;
         end else begin
            rsp_ch.ready = 1'b1;
            hold = idle_len();
         end
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.first    = rsp_ch.group_first;
            got.last     = rsp_ch.group_last;
            got.count    = rsp_ch.group_count;
            got.run_last = rsp_ch.run_last;
            tracker.check_group(got);
         end
         @(negedge clock);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

FILE: range_adaptive_point_grouper.f
+incdir+rtl
rtl/rapg_pkg.sv
rtl/rapg_if.sv
rtl/rapg_isqrt.sv
rtl/rapg_datapath.sv
rtl/rapg_control.sv
rtl/range_adaptive_point_grouper.sv
verif/tb_top.sv
